// ===== rtl/core/plhc_pkg.sv =====
// Shared constants, types and tables for the path loss heatmap pixel colorizer.
package plhc_pkg;

	localparam int MAP_SIZE      = 1024;
	localparam int LOG_FRAC_BITS = 8;

	localparam int COORD_W = 10;
	localparam int LB_W    = 16;
	localparam int CH_W    = 8;
	localparam int BAND_W  = 4;
	localparam int PWR_O_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int SQ_W    = 2 * COORD_W;
	localparam int D2_W    = SQ_W + 1;
	localparam int POS_W   = $clog2(D2_W);
	localparam int LOG_Q   = 16;
	localparam int L2_W    = POS_W + LOG_Q;
	localparam int SCALE_W = 26;
	localparam int PROD_W  = L2_W + SCALE_W;
	localparam int RND_SH  = 32;
	localparam int DB_W    = PROD_W - RND_SH;
	localparam int PWR_W   = ((LB_W > DB_W) ? LB_W : DB_W) + 2;

	localparam logic [SCALE_W-1:0] LOG_SCALE = SCALE_W'(50504453);

	localparam int BAND_TOP    = -44 * 256;
	localparam int BAND_BOTTOM = -144 * 256;
	localparam int BAND_STEP   = 10 * 256;
	localparam int NUM_BANDS   = 10;

	localparam logic [BAND_W-1:0] BAND_NONE = BAND_W'(NUM_BANDS);

	localparam logic signed [PWR_O_W-1:0] PWR_MAX = {1'b0, {(PWR_O_W-1){1'b1}}};
	localparam logic signed [PWR_O_W-1:0] PWR_MIN = {1'b1, {(PWR_O_W-1){1'b0}}};

	localparam logic [COORD_W-1:0] STATION_X_RST   = COORD_W'(500);
	localparam logic [COORD_W-1:0] STATION_Y_RST   = COORD_W'(500);
	localparam logic [LB_W-1:0]    LINK_BUDGET_RST = LB_W'(-11713);

	localparam int LOG_TBL_N = 1 << LOG_FRAC_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STATION_X   = 2'd0,
		REG_STATION_Y   = 2'd1,
		REG_LINK_BUDGET = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic            zero;
		logic [DB_W-1:0] db;
	} db_res_t;

	typedef struct packed {
		logic signed [PWR_O_W-1:0] power_level;
		logic [BAND_W-1:0]         band;
		logic [CH_W-1:0]           blue;
		logic [CH_W-1:0]           green;
		logic [CH_W-1:0]           red;
	} pix_res_t;

	typedef logic [LOG_Q-1:0] log_tbl_t [LOG_TBL_N];

	function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] c);
		logic [COORD_W-1:0] r;
		r = c;
		if (int'(c) > MAP_SIZE - 1) begin
			r = COORD_W'(MAP_SIZE - 1);
		end
		return r;
	endfunction

	// log2(1 + k/2^F) in Q16 by repeated squaring, truncated
	function automatic logic [LOG_Q-1:0] mant_log2(int unsigned k);
		logic [63:0]      x;
		logic [LOG_Q-1:0] r;
		x = (64'(1 << LOG_FRAC_BITS) + 64'(k)) << (30 - LOG_FRAC_BITS);
		r = '0;
		for (int i = LOG_Q - 1; i >= 0; i--) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic log_tbl_t build_log_tbl();
		log_tbl_t t;
		for (int k = 0; k < LOG_TBL_N; k++) begin
			t[k] = mant_log2(k);
		end
		return t;
	endfunction

	localparam log_tbl_t LOG_TBL = build_log_tbl();

	function automatic logic [3*CH_W-1:0] band_colour(logic [BAND_W-1:0] b);
		logic [3*CH_W-1:0] c;
		unique case (b)
			4'd0:    c = {8'd255, 8'd0,   8'd0};
			4'd1:    c = {8'd220, 8'd50,  8'd0};
			4'd2:    c = {8'd255, 8'd165, 8'd0};
			4'd3:    c = {8'd255, 8'd255, 8'd0};
			4'd4:    c = {8'd173, 8'd255, 8'd47};
			4'd5:    c = {8'd0,   8'd255, 8'd0};
			4'd6:    c = {8'd0,   8'd250, 8'd154};
			4'd7:    c = {8'd102, 8'd205, 8'd170};
			4'd8:    c = {8'd65,  8'd105, 8'd225};
			4'd9:    c = {8'd0,   8'd0,   8'd255};
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/plhc_dist.sv =====
// Squared pixel distance to the base station: input register, squares, sum.
module plhc_dist
	import plhc_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [COORD_W-1:0] station_x,
	input  logic [COORD_W-1:0] station_y,
	output logic [D2_W-1:0]    d2_s3
);

	logic [COORD_W-1:0]      px_s1;
	logic [COORD_W-1:0]      py_s1;
	logic [SQ_W-1:0]         sqx_s2;
	logic [SQ_W-1:0]         sqy_s2;
	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	logic signed [2*COORD_W+1:0] pxx;
	logic signed [2*COORD_W+1:0] pyy;

	assign dx  = $signed({1'b0, px_s1}) - $signed({1'b0, station_x});
	assign dy  = $signed({1'b0, py_s1}) - $signed({1'b0, station_y});
	assign pxx = dx * dx;
	assign pyy = dy * dy;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= clamp_coord(pixel_x);
			py_s1  <= clamp_coord(pixel_y);
			sqx_s2 <= pxx[SQ_W-1:0];
			sqy_s2 <= pyy[SQ_W-1:0];
			d2_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		end
	end

endmodule

// ===== rtl/core/plhc_log.sv =====
// Distance in 1/256 dB: leading one and mantissa table, then scale and round.
module plhc_log
	import plhc_pkg::*;
(
	input  logic            clk,
	input  logic            en,
	input  logic [D2_W-1:0] d2_s3,
	output db_res_t         db_s5
);

	logic [L2_W-1:0]                l2_s4;
	logic                           zero_s4;
	logic [POS_W-1:0]               pos;
	logic [D2_W+LOG_FRAC_BITS-1:0]  norm;
	logic [LOG_FRAC_BITS-1:0]       mant;
	logic [PROD_W-1:0]              prod;

	always_comb begin
		pos = '0;
		for (int i = 0; i < D2_W; i++) begin
			if (d2_s3[i]) begin
				pos = POS_W'(i);
			end
		end
	end

	assign norm = {d2_s3, {LOG_FRAC_BITS{1'b0}}} >> pos;
	assign mant = norm[LOG_FRAC_BITS-1:0];
	assign prod = PROD_W'(l2_s4) * PROD_W'(LOG_SCALE) + (PROD_W'(1) << (RND_SH - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			l2_s4      <= {pos, LOG_TBL[mant]};
			zero_s4    <= (d2_s3 == '0);
			db_s5.db   <= prod[PROD_W-1:RND_SH];
			db_s5.zero <= zero_s4;
		end
	end

endmodule

// ===== rtl/core/plhc_band.sv =====
// Received power, band sort, colour lookup, held colour and result register.
module plhc_band
	import plhc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  db_res_t         db_s5,
	input  logic [LB_W-1:0] link_budget,
	output pix_res_t        res_q
);

	logic signed [PWR_W-1:0]  power;
	logic [BAND_W-1:0]        band;
	logic [BAND_W-1:0]        cnt;
	logic [3*CH_W-1:0]        held_colour_q;
	logic [3*CH_W-1:0]        colour;
	logic signed [PWR_O_W-1:0] sat;

	assign power = PWR_W'($signed(link_budget)) - $signed({{(PWR_W-DB_W){1'b0}}, db_s5.db});

	always_comb begin
		cnt = '0;
		for (int i = 1; i < NUM_BANDS; i++) begin
			if (power < PWR_W'(BAND_TOP - i * BAND_STEP)) begin
				cnt = cnt + 1'b1;
			end
		end
	end

	always_comb begin
		priority if (db_s5.zero) begin
			band = BAND_NONE;
		end else if (power >= PWR_W'(BAND_TOP) || power < PWR_W'(BAND_BOTTOM)) begin
			band = BAND_NONE;
		end else begin
			band = cnt;
		end
	end

	always_comb begin
		priority if (db_s5.zero) begin
			sat = PWR_MAX;
		end else if (power < PWR_W'(PWR_MIN)) begin
			sat = PWR_MIN;
		end else if (power > PWR_W'(PWR_MAX)) begin
			sat = PWR_MAX;
		end else begin
			sat = power[PWR_O_W-1:0];
		end
	end

	assign colour = (band == BAND_NONE) ? held_colour_q : band_colour(band);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_colour_q <= '0;
		end else if (load) begin
			held_colour_q <= colour;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.red         <= colour[3*CH_W-1:2*CH_W];
			res_q.green       <= colour[2*CH_W-1:CH_W];
			res_q.blue        <= colour[CH_W-1:0];
			res_q.band        <= band;
			res_q.power_level <= sat;
		end
	end

	a_colour_tracks_held: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> {res_q.red, res_q.green, res_q.blue} == held_colour_q)
		else $error("result colour differs from held colour");

	a_zero_distance: assert property (@(posedge clk) disable iff (!arst_n)
		load && db_s5.zero |=> res_q.band == BAND_NONE && res_q.power_level == PWR_MAX)
		else $error("zero distance item not flagged outside bands at full power");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res_q.band <= BAND_NONE)
		else $error("band code out of range");

	a_band_below_top: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res_q.band == BAND_NONE || res_q.power_level < PWR_O_W'(BAND_TOP))
		else $error("banded item with power above the strongest band");

	a_hold_outside: assert property (@(posedge clk) disable iff (!arst_n)
		load && band == BAND_NONE |=> $stable(held_colour_q))
		else $error("held colour changed on an item outside all bands");

endmodule

// ===== rtl/core/path_loss_heatmap_pixel_colorizer_unit.sv =====
// Top level of the path loss heatmap pixel colorizer: config registers and item flow.
//
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// s_axis   | s_axis_tvalid/s_axis_tready | tdata: pixel_x, pixel_y
// m_axis   | m_axis_tvalid/m_axis_tready | tdata: red, green, blue, band, power_level
// cfg      | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// One item per cycle while results are taken; after its item enters the input register, a
// result passes the squares, distance sum, log table, scale multiply and result registers.
// All stages advance together; a result not taken stalls every stage and s_axis_tready.
// Reset restores the station at 500,500, link budget -11713/256 dB and a black held colour.
// cfg_ready is always high; a write takes effect in the next cycle.
module path_loss_heatmap_pixel_colorizer_unit
	import plhc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // pixel_x[9:0], pixel_y[19:10], zero pad
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [47:0]           m_axis_tdata,  // red, green, blue, band, power_level, pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NUM_STAGES = 5;

	logic [COORD_W-1:0]    station_x_q;
	logic [COORD_W-1:0]    station_y_q;
	logic [LB_W-1:0]       link_budget_q;
	logic [NUM_STAGES-1:0] stage_v_q;
	logic                  out_valid_q;
	logic                  en;
	logic [D2_W-1:0]       d2_s3;
	db_res_t               db_s5;
	pix_res_t              res_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_x_q   <= STATION_X_RST;
			station_y_q   <= STATION_Y_RST;
			link_budget_q <= LINK_BUDGET_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STATION_X:   station_x_q   <= clamp_coord(cfg_data[COORD_W-1:0]);
				REG_STATION_Y:   station_y_q   <= clamp_coord(cfg_data[COORD_W-1:0]);
				REG_LINK_BUDGET: link_budget_q <= cfg_data[LB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_v_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			stage_v_q   <= {stage_v_q[NUM_STAGES-2:0], s_axis_tvalid};
			out_valid_q <= stage_v_q[NUM_STAGES-1];
		end
	end

	plhc_dist u_dist (
		.clk       (clk),
		.en        (en),
		.pixel_x   (s_axis_tdata[COORD_W-1:0]),
		.pixel_y   (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.station_x (station_x_q),
		.station_y (station_y_q),
		.d2_s3     (d2_s3)
	);

	plhc_log u_log (
		.clk   (clk),
		.en    (en),
		.d2_s3 (d2_s3),
		.db_s5 (db_s5)
	);

	plhc_band u_band (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (en && stage_v_q[NUM_STAGES-1]),
		.db_s5       (db_s5),
		.link_budget (link_budget_q),
		.res_q       (res_q)
	);

endmodule
